// File: rtl/assert_macros.svh
// assertion macros for the rtl files, included by the top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("implication check failed");
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_IMPL(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/ugca_pkg.sv
// types, constants and codes shared by the glyph cell allocator
package ugca_pkg;

  localparam int unsigned MAX_GLYPHS_DEF     = 4096;
  localparam int unsigned COVERAGE_BYTES_DEF = 1048576;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int GN_W    = 12;
  localparam int OFF_W   = 20;
  localparam int TG_W    = 13;
  localparam int TC_W    = 21;
  localparam int CELL_W  = 16;
  localparam int IDX_W   = 2;
  localparam int CFG_W   = 21;
  localparam int TDATA_W = 96;
  localparam int TPAD_W  = TDATA_W - (CP_W + GN_W + OFF_W + TG_W + TC_W + 2);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // register indexes
  localparam logic [IDX_W-1:0] REG_CELL_WIDTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_CELL_HEIGHT = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_GLYPHS  = 2'd2;
  localparam logic [IDX_W-1:0] REG_COV_CAP     = 2'd3;

  localparam logic [7:0]      RST_CELL_WIDTH  = 8'd8;
  localparam logic [7:0]      RST_CELL_HEIGHT = 8'd16;
  localparam logic [TG_W-1:0] RST_MAX_GLYPHS  = 13'd4096;
  localparam logic [TC_W-1:0] RST_COV_CAP     = 21'd1048576;

  // utf-8 lead and continuation patterns
  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] NEWLINE    = 8'h0A;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] LEAD2_BITS = 8'h1F;
  localparam logic [7:0] LEAD3_BITS = 8'h0F;
  localparam logic [7:0] LEAD4_BITS = 8'h07;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    FAIL_NONE     = 2'd0,
    FAIL_UTF8     = 2'd1,
    FAIL_GLYPHS   = 2'd2,
    FAIL_COVERAGE = 2'd3
  } fail_t;

  typedef struct packed {
    logic [7:0]      cell_width;
    logic [7:0]      cell_height;
    logic [TG_W-1:0] max_glyphs;
    logic [TC_W-1:0] coverage_capacity;
  } cfg_t;

  // one decoded event handed from the front to the back
  typedef struct packed {
    logic            glyph;
    logic            bad_utf8;
    logic            last;
    logic [CP_W-1:0] codepoint;
  } token_t;

  typedef struct packed {
    kind_t            kind;
    logic [CP_W-1:0]  codepoint;
    logic [GN_W-1:0]  glyph_number;
    logic [OFF_W-1:0] cell_offset;
    logic [TG_W-1:0]  total_glyphs;
    logic [TC_W-1:0]  total_coverage;
    fail_t            fail_code;
    logic             final_result;
  } result_t;

endpackage

// File: rtl/utf8_glyph_cell_allocator.sv
// UTF-8 byte stream in, glyph cell allocation records out.
// Input beats on s_*: one byte each, s_tlast on the final byte of a string.
// Output beats on m_*: m_tuser gives the record kind (glyph, string done,
// string failed), m_tlast marks the last record caused by one input byte.
// A glyph on the end byte yields the glyph record and then the done record.
// Throughput is one byte per cycle while the queue has room, one record per
// cycle on the output while m_tready is high; the output register is the
// only limit when a byte yields two records. A four-entry token queue sits
// between the decoder and the allocator, so bytes keep flowing while a
// record waits on m_tready; s_tready drops only once that queue fills.
// After a failed record the rest of that string gives no records.
// Reset clears the decoder, the counters, the queue and the output, and
// loads the registers with cell 8 by 16, 4096 glyphs and 1 MiB of coverage.
// Registers are written through cfg_wen/cfg_index/cfg_wdata; the user must
// write them only while idle; the block does not enforce it.
`include "assert_macros.svh"
module utf8_glyph_cell_allocator import ugca_pkg::*; #(
  parameter int unsigned MAX_GLYPHS     = MAX_GLYPHS_DEF,
  parameter int unsigned COVERAGE_BYTES = COVERAGE_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // text_byte[7:0]
  input  logic               s_tlast,
  output logic               m_tvalid,
  input  logic               m_tready,
  // glyph_codepoint[20:0], glyph_number[32:21], cell_offset[52:33],
  // total_glyphs[65:53], total_coverage[86:66], fail_code[88:87], zero above
  output logic [TDATA_W-1:0] m_tdata,
  output logic [1:0]         m_tuser,   // result_kind[1:0]
  output logic               m_tlast,
  input  logic               cfg_wen,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  cfg_t    cfg;
  token_t  front_tok, head;
  logic    tok_push, q_pop, q_empty, q_full, done_pending;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_width        <= RST_CELL_WIDTH;
      cfg.cell_height       <= RST_CELL_HEIGHT;
      cfg.max_glyphs        <= RST_MAX_GLYPHS;
      cfg.coverage_capacity <= RST_COV_CAP;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CELL_WIDTH:  cfg.cell_width        <= cfg_wdata[7:0];
        REG_CELL_HEIGHT: cfg.cell_height       <= cfg_wdata[7:0];
        REG_MAX_GLYPHS:  cfg.max_glyphs        <= cfg_wdata[TG_W-1:0];
        REG_COV_CAP:     cfg.coverage_capacity <= cfg_wdata[TC_W-1:0];
        default:         cfg                   <= cfg;
      endcase
    end
  end

  ugca_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (s_tvalid),
    .byte_ready    (s_tready),
    .text_byte     (s_tdata),
    .end_of_string (s_tlast),
    .q_full        (q_full),
    .tok_push      (tok_push),
    .tok           (front_tok)
  );

  ugca_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (tok_push),
    .push_tok (front_tok),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ugca_back #(
    .MAX_GLYPHS     (MAX_GLYPHS),
    .COVERAGE_BYTES (COVERAGE_BYTES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .head_valid   (!q_empty),
    .pop          (q_pop),
    .done_pending (done_pending),
    .res          (res),
    .res_valid    (m_tvalid),
    .res_ready    (m_tready)
  );

  assign m_tdata = {{TPAD_W{1'b0}}, res.fail_code, res.total_coverage, res.total_glyphs,
                    res.cell_offset, res.glyph_number, res.codepoint};
  assign m_tuser = res.kind;
  assign m_tlast = res.final_result;

  `ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && q_empty)
  `ASSERT_IMPL(a_glyph_before_done, clk, rst, $rose(done_pending) |-> (m_tvalid && m_tuser == KIND_GLYPH && !m_tlast))
  `ASSERT_IMPL(a_end_records_final, clk, rst, (m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_FAIL)) |-> m_tlast)

endmodule

// File: rtl/ugca_front.sv
// utf-8 decode front end: turns input beats into glyph, error and end tokens
module ugca_front import ugca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_ready,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic              end_of_string,
  input  logic              q_full,
  output logic              tok_push,
  output token_t            tok
);

  logic [1:0]      pending, pending_next;
  logic [CP_W-1:0] acc, acc_next;
  logic            failed, failed_next;
  logic            bad, complete, newline, emit;

  assign byte_ready = !q_full;

  always_comb begin
    pending_next = pending;
    acc_next     = acc;
    failed_next  = failed;
    bad          = 1'b0;
    complete     = 1'b0;
    newline      = 1'b0;
    tok          = '0;
    tok.last     = end_of_string;
    if (failed) begin
      emit = end_of_string;
      if (end_of_string) begin
        failed_next  = 1'b0;
        pending_next = 2'd0;
        acc_next     = '0;
      end
    end else begin
      if (pending == 2'd0) begin
        if (text_byte <= ASCII_MAX) begin
          acc_next = CP_W'(text_byte);
          complete = 1'b1;
          newline  = (text_byte == NEWLINE);
        end else if ((text_byte & LEAD2_MASK) == LEAD2_CODE) begin
          acc_next     = CP_W'(text_byte & LEAD2_BITS);
          pending_next = 2'd1;
        end else if ((text_byte & LEAD3_MASK) == LEAD3_CODE) begin
          acc_next     = CP_W'(text_byte & LEAD3_BITS);
          pending_next = 2'd2;
        end else if ((text_byte & LEAD4_MASK) == LEAD4_CODE) begin
          acc_next     = CP_W'(text_byte & LEAD4_BITS);
          pending_next = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else begin
        if ((text_byte & CONT_MASK) != CONT_CODE) begin
          bad = 1'b1;
        end else begin
          acc_next     = {acc[CP_W-7:0], text_byte[5:0]};
          pending_next = pending - 2'd1;
          complete     = (pending == 2'd1);
        end
      end
      tok.codepoint = acc_next;
      tok.glyph     = !bad && complete && !newline;
      // truncated sequence counts as bad utf-8
      tok.bad_utf8  = bad || (end_of_string && pending_next != 2'd0);
      emit          = tok.glyph || tok.bad_utf8 || end_of_string;
      if (end_of_string) begin
        failed_next  = 1'b0;
        pending_next = 2'd0;
        acc_next     = '0;
      end else if (tok.bad_utf8) begin
        failed_next = 1'b1;
      end
    end
  end

  assign tok_push = byte_valid && byte_ready && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
      acc     <= '0;
      failed  <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      pending <= pending_next;
      acc     <= acc_next;
      failed  <= failed_next;
    end
  end

endmodule

// File: rtl/ugca_queue.sv
// short token queue between the decode front and the allocation back
module ugca_queue import ugca_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_tok,
  input  logic   pop,
  output token_t head,
  output logic   empty,
  output logic   full
);

  token_t            slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/ugca_back.sv
// allocation back end: glyph and coverage budgets, result register
module ugca_back import ugca_pkg::*; #(
  parameter int unsigned MAX_GLYPHS     = MAX_GLYPHS_DEF,
  parameter int unsigned COVERAGE_BYTES = COVERAGE_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  token_t  head,
  input  logic    head_valid,
  output logic    pop,
  output logic    done_pending,
  output result_t res,
  output logic    res_valid,
  input  logic    res_ready
);

  localparam logic [31:0] GLIM_MAX = 32'(MAX_GLYPHS);
  localparam logic [31:0] CLIM_MAX = 32'(COVERAGE_BYTES);

  logic [TG_W-1:0]   glyph_cnt, glyph_cnt_next;
  logic [TC_W-1:0]   cov_cnt, cov_cnt_next;
  logic              failed, failed_next;
  logic              done_pending_next;
  logic              out_free, load;
  result_t           res_next;
  logic [TG_W-1:0]   glim;
  logic [TC_W-1:0]   clim;
  logic [7:0]        w, h;
  logic [CELL_W-1:0] cell_size;
  logic              over_glyphs, over_cov, fail_now;
  fail_t             fcode;

  always_comb begin
    glim = (32'(cfg.max_glyphs) > GLIM_MAX) ? GLIM_MAX[TG_W-1:0] : cfg.max_glyphs;
    clim = (32'(cfg.coverage_capacity) > CLIM_MAX) ? CLIM_MAX[TC_W-1:0]
                                                    : cfg.coverage_capacity;
    w    = (cfg.cell_width == 8'd0) ? 8'd1 : cfg.cell_width;
    h    = (cfg.cell_height == 8'd0) ? 8'd1 : cfg.cell_height;
    cell_size = {8'd0, w} * {8'd0, h};
    over_glyphs = (glyph_cnt >= glim);
    over_cov    = (cov_cnt > clim) || (TC_W'(cell_size) > (clim - cov_cnt));
  end

  assign out_free = !res_valid || res_ready;

  always_comb begin
    glyph_cnt_next    = glyph_cnt;
    cov_cnt_next      = cov_cnt;
    failed_next       = failed;
    done_pending_next = done_pending;
    pop               = 1'b0;
    load              = 1'b0;
    fail_now          = 1'b0;
    fcode             = FAIL_NONE;
    res_next          = '0;
    res_next.kind     = KIND_GLYPH;
    res_next.fail_code = FAIL_NONE;
    if (head_valid && out_free) begin
      if (done_pending) begin
        // second beat of a glyph on the end byte
        load                    = 1'b1;
        pop                     = 1'b1;
        res_next.kind           = KIND_DONE;
        res_next.total_glyphs   = glyph_cnt;
        res_next.total_coverage = cov_cnt;
        res_next.final_result   = 1'b1;
        done_pending_next       = 1'b0;
        glyph_cnt_next          = '0;
        cov_cnt_next            = '0;
      end else if (failed) begin
        // rest of a failed string is dropped
        pop = 1'b1;
        if (head.last) begin
          failed_next    = 1'b0;
          glyph_cnt_next = '0;
          cov_cnt_next   = '0;
        end
      end else begin
        load = 1'b1;
        if (head.glyph) begin
          if (over_glyphs) begin
            fail_now = 1'b1;
            fcode    = FAIL_GLYPHS;
          end else if (over_cov) begin
            fail_now = 1'b1;
            fcode    = FAIL_COVERAGE;
          end else begin
            res_next.kind         = KIND_GLYPH;
            res_next.codepoint    = head.codepoint;
            res_next.glyph_number = glyph_cnt[GN_W-1:0];
            res_next.cell_offset  = cov_cnt[OFF_W-1:0];
            res_next.final_result = !head.last;
            glyph_cnt_next        = glyph_cnt + 1'b1;
            cov_cnt_next          = cov_cnt + TC_W'(cell_size);
            if (head.last) begin
              done_pending_next = 1'b1;
            end else begin
              pop = 1'b1;
            end
          end
        end else if (head.bad_utf8) begin
          fail_now = 1'b1;
          fcode    = FAIL_UTF8;
        end else begin
          pop                     = 1'b1;
          res_next.kind           = KIND_DONE;
          res_next.total_glyphs   = glyph_cnt;
          res_next.total_coverage = cov_cnt;
          res_next.final_result   = 1'b1;
          glyph_cnt_next          = '0;
          cov_cnt_next            = '0;
        end
        if (fail_now) begin
          pop                   = 1'b1;
          res_next              = '0;
          res_next.kind         = KIND_FAIL;
          res_next.fail_code    = fcode;
          res_next.final_result = 1'b1;
          glyph_cnt_next        = glyph_cnt;
          cov_cnt_next          = cov_cnt;
          if (head.last) begin
            glyph_cnt_next = '0;
            cov_cnt_next   = '0;
          end else begin
            failed_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_cnt    <= '0;
      cov_cnt      <= '0;
      failed       <= 1'b0;
      done_pending <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      glyph_cnt    <= glyph_cnt_next;
      cov_cnt      <= cov_cnt_next;
      failed       <= failed_next;
      done_pending <= done_pending_next;
      if (out_free) res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res <= res_next;
  end

endmodule
